### hdl/sensor_frame_receiver_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// sensor frame receiver: assertion macros
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_RECEIVER_DECODER_UNIT_MACROS_SVH
`define SENSOR_FRAME_RECEIVER_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SFRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfrd assertion failed");
// next-cycle implication
`define SFRD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfrd assertion failed");
`else
`define SFRD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFRD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/sfrd_pkg.sv
// ----------------------------------------------------------------------------
// sfrd_pkg
// shared types and constants of the sensor frame receiver
// ----------------------------------------------------------------------------
package sfrd_pkg;

	localparam int MAX_FRAME_LEN_DEF = 64;
	localparam int MIN_FRAME_LEN     = 5;
	localparam int STORE_DEPTH       = 16;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'h7E;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h23;

	localparam logic [7:0] FN_VERSION = 8'h01;
	localparam logic [7:0] FN_MOTION  = 8'h04;
	localparam logic [7:0] FN_EULER   = 8'h26;
	localparam logic [7:0] FN_BARO    = 8'h32;

	localparam logic [7:0] PLEN_MOTION  = 8'd12;
	localparam logic [7:0] PLEN_EULER   = 8'd12;
	localparam logic [7:0] PLEN_BARO    = 8'd16;
	localparam logic [7:0] PLEN_VERSION = 8'd3;

	typedef enum logic [1:0] {
		KIND_MOTION  = 2'd0,
		KIND_EULER   = 2'd1,
		KIND_BARO    = 2'd2,
		KIND_VERSION = 2'd3
	} kind_t;

	typedef logic [STORE_DEPTH-1:0][7:0] payload_t;

	// one checked frame on its way to the formatter
	typedef struct packed {
		kind_t    kind;
		payload_t bytes;
	} frame_rec_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} frame_push_t;

endpackage

### hdl/sfrd_front.sv
// ----------------------------------------------------------------------------
// sfrd_front
// byte parser: sync hunt, length check, payload capture, checksum and
// frame classification
// ----------------------------------------------------------------------------
module sfrd_front #(
	parameter int MAX_FRAME_LEN = sfrd_pkg::MAX_FRAME_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_acc,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           sync_first,
	input  logic [7:0]           sync_second,
	output sfrd_pkg::frame_push_t push_o
);
	import sfrd_pkg::*;

	localparam int IDX_BITS = $clog2(MAX_FRAME_LEN + 1);
	localparam int IDX_W    = (IDX_BITS > 5) ? IDX_BITS : 5;
	localparam int SW       = $clog2(STORE_DEPTH);

	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_FUNC  = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       length_q;
	logic [7:0]       func_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	payload_t         store_q;

	logic [7:0] plen;
	logic       last_byte;
	logic       known;
	kind_t      kind;

	assign plen      = length_q - 8'(MIN_FRAME_LEN);
	assign last_byte = (8'(idx_q) >= plen);

	always_comb begin
		known = 1'b0;
		kind  = KIND_MOTION;
		case (func_q)
			FN_MOTION: begin
				known = (plen >= PLEN_MOTION);
				kind  = KIND_MOTION;
			end
			FN_EULER: begin
				known = (plen >= PLEN_EULER);
				kind  = KIND_EULER;
			end
			FN_BARO: begin
				known = (plen >= PLEN_BARO);
				kind  = KIND_BARO;
			end
			FN_VERSION: begin
				known = (plen >= PLEN_VERSION);
				kind  = KIND_VERSION;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign push_o.valid     = in_acc && (phase_q == PH_DATA) && last_byte
	                          && (rx_byte == sum_q) && known;
	assign push_o.rec.kind  = kind;
	assign push_o.rec.bytes = store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			length_q <= '0;
			func_q   <= '0;
			idx_q    <= '0;
			sum_q    <= '0;
		end else if (in_acc) begin
			case (phase_q)
				PH_SYNC1: begin
					if (rx_byte == sync_first) phase_q <= PH_SYNC2;
				end
				PH_SYNC2: begin
					if (rx_byte == sync_second) phase_q <= PH_LEN;
					else if (rx_byte == sync_first) phase_q <= PH_SYNC2;
					else phase_q <= PH_SYNC1;
				end
				PH_LEN: begin
					length_q <= rx_byte;
					if (rx_byte < 8'(MIN_FRAME_LEN) || rx_byte > 8'(MAX_FRAME_LEN))
						phase_q <= PH_SYNC1;
					else
						phase_q <= PH_FUNC;
				end
				PH_FUNC: begin
					func_q  <= rx_byte;
					idx_q   <= '0;
					sum_q   <= sync_first + sync_second + length_q + rx_byte;
					phase_q <= PH_DATA;
				end
				PH_DATA: begin
					if (last_byte) begin
						phase_q <= PH_SYNC1;
					end else begin
						sum_q <= sum_q + rx_byte;
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					phase_q <= PH_SYNC1;
				end
			endcase
		end
	end

	// payload capture, first bytes of the frame only
	always_ff @(posedge clk) begin
		if (in_acc && phase_q == PH_DATA && !last_byte
		    && idx_q < IDX_W'(STORE_DEPTH))
			store_q[idx_q[SW-1:0]] <= rx_byte;
	end

endmodule

### hdl/sfrd_queue.sv
// ----------------------------------------------------------------------------
// sfrd_queue
// short queue of checked frames between parser and formatter
// ----------------------------------------------------------------------------
module sfrd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfrd_pkg::frame_push_t push_i,
	input  logic                  pop_i,
	output sfrd_pkg::frame_rec_t  head_o,
	output logic                  full_o,
	output logic                  empty_o
);
	import sfrd_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	frame_rec_t    mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full_o  = (count_q == CW'(QUEUE_DEPTH));
	assign empty_o = (count_q == '0);
	assign head_o  = mem_q[rd_ptr_q];
	assign do_push = push_i.valid && !full_o;
	assign do_pop  = pop_i && !empty_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_i.rec;
	end

endmodule

### hdl/sfrd_back.sv
// ----------------------------------------------------------------------------
// sfrd_back
// record formatter: builds the result words and holds them for the reader
// ----------------------------------------------------------------------------
module sfrd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfrd_pkg::frame_rec_t head_i,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [1:0]           record_kind,
	output logic [31:0]          word0,
	output logic [31:0]          word1,
	output logic [31:0]          word2,
	output logic [31:0]          word3,
	output logic [31:0]          word4,
	output logic [31:0]          word5
);
	import sfrd_pkg::*;

	logic              valid_q;
	kind_t             kind_q;
	logic [5:0][31:0]  words_q;
	logic [5:0][31:0]  words_d;

	always_comb begin
		words_d = '0;
		case (head_i.kind)
			KIND_MOTION: begin
				for (int k = 0; k < 6; k++)
					words_d[k] = {{16{head_i.bytes[2*k+1][7]}},
					              head_i.bytes[2*k+1], head_i.bytes[2*k]};
			end
			KIND_EULER, KIND_BARO: begin
				for (int k = 0; k < 4; k++)
					words_d[k] = {head_i.bytes[4*k+3], head_i.bytes[4*k+2],
					              head_i.bytes[4*k+1], head_i.bytes[4*k]};
				// euler carries three words only
				if (head_i.kind == KIND_EULER) words_d[3] = '0;
			end
			KIND_VERSION: begin
				for (int k = 0; k < 3; k++)
					words_d[k] = {24'd0, head_i.bytes[k]};
			end
			default: begin
				words_d = '0;
			end
		endcase
	end

	assign q_pop = !q_empty && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q  <= head_i.kind;
			words_q <= words_d;
		end
	end

	assign empty       = !valid_q;
	assign record_kind = kind_q;
	assign word0       = words_q[0];
	assign word1       = words_q[1];
	assign word2       = words_q[2];
	assign word3       = words_q[3];
	assign word4       = words_q[4];
	assign word5       = words_q[5];

endmodule

### hdl/sensor_frame_receiver_decoder_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_receiver_decoder_unit
// sync-byte serial frame receiver with additive checksum and record decode
// ----------------------------------------------------------------------------
// usage:
//   input queue: drive rx_byte and push; a beat is taken when full is low.
//   one byte is taken every cycle while full is low; full rises only while
//   two decoded frames wait behind an unread result.
//   result queue: while empty is low, record_kind and word0..word5 hold the
//   oldest record; pop takes it.
//   the edge that takes the beat carrying a good checksum writes its record
//   into the parser-to-formatter queue; the output register then loads it
//   from the queue head once that register is empty or being popped.
//   bytes of bad, unknown or short frames produce nothing.
//   the APB port writes sync_first at address 0 and sync_second at address 4;
//   write it only while no frame is in progress.
//   reset returns the parser to the sync hunt, empties both queues and
//   restores the sync bytes to 0x7E and 0x23.
//   a stalled reader keeps its record; the parser goes on until the queue
//   fills, then full holds the sender off.
// ----------------------------------------------------------------------------
`include "sensor_frame_receiver_decoder_unit_macros.svh"

module sensor_frame_receiver_decoder_unit #(
	parameter int MAX_FRAME_LEN = sfrd_pkg::MAX_FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  record_kind,
	output logic [31:0] word0,
	output logic [31:0] word1,
	output logic [31:0] word2,
	output logic [31:0] word3,
	output logic [31:0] word4,
	output logic [31:0] word5,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sfrd_pkg::*;

	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic        cfg_wr;
	logic        in_acc;
	frame_push_t push_w;
	frame_rec_t  head_w;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {24'd0, paddr[2] ? sync_second_q : sync_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) sync_second_q <= pwdata[7:0];
			else sync_first_q <= pwdata[7:0];
		end
	end

	assign full   = q_full;
	assign in_acc = push && !full;

	sfrd_front #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_acc     (in_acc),
		.rx_byte    (rx_byte),
		.sync_first (sync_first_q),
		.sync_second(sync_second_q),
		.push_o     (push_w)
	);

	sfrd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_i (push_w),
		.pop_i  (q_pop),
		.head_o (head_w),
		.full_o (q_full),
		.empty_o(q_empty)
	);

	sfrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_i     (head_w),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.record_kind(record_kind),
		.word0      (word0),
		.word1      (word1),
		.word2      (word2),
		.word3      (word3),
		.word4      (word4),
		.word5      (word5)
	);

	// a frame record is never offered to a full queue
	`SFRD_ASSERT_IMP(a_no_overflow, clk, arst_n, push_w.valid, !q_full)
	// the formatter only takes from a non-empty queue
	`SFRD_ASSERT_IMP(a_pop_nonempty, clk, arst_n, q_pop, !q_empty)
	// a waiting record reaches the output register in the next cycle
	`SFRD_ASSERT_NXT(a_fill_output, clk, arst_n, empty && !q_empty, !empty)

endmodule
